// ===== hw/rtl/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared constants, register indexes and types of the sprite frame sequencer.
// ----------------------------------------------------------------------------
package sfs_pkg;

    localparam int ORDER_DEPTH = 256;
    localparam int ADDR_W      = $clog2(ORDER_DEPTH);

    // divider: 13-bit dividend, 7-bit divisor, one quotient bit per cycle
    localparam int DIV_N_W   = 13;
    localparam int DIV_D_W   = 7;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    localparam int FRAME_W = 12;
    localparam int POS_W   = 18;
    localparam int SIZE_W  = 13;
    localparam int LEN_W   = 13;

    localparam logic [25:0] POS_MAX  = 26'd262143;
    localparam logic [13:0] LEN_MAX  = 14'd4096;

    typedef enum logic [2:0] {
        CFG_SHEET_COLS    = 3'd0,
        CFG_SHEET_ROWS    = 3'd1,
        CFG_FRAME_PERIOD  = 3'd2,
        CFG_SHEET_WIDTH   = 3'd3,
        CFG_SHEET_HEIGHT  = 3'd4,
        CFG_USE_CUSTOM    = 3'd5,
        CFG_ORDER_LENGTH  = 3'd6
    } t_cfg_idx;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FRAME = 1'b1;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quot;
        logic [DIV_D_W-1:0] rem;
    } t_div_out;

endpackage

// ===== hw/rtl/sfs_order_ram.sv =====
// ----------------------------------------------------------------------------
// sfs_order_ram
// Draw-order table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sfs_order_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [sfs_pkg::ADDR_W-1:0]  i_waddr,
    input  logic [sfs_pkg::FRAME_W-1:0] i_wdata,
    input  logic [sfs_pkg::ADDR_W-1:0]  i_raddr,
    output logic [sfs_pkg::FRAME_W-1:0] o_rdata
);

    logic [sfs_pkg::FRAME_W-1:0] r_mem [sfs_pkg::ORDER_DEPTH];
    logic [sfs_pkg::FRAME_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/sfs_div.sv =====
// ----------------------------------------------------------------------------
// sfs_div
// Restoring unsigned divider, one quotient bit per cycle. Divisor nonzero.
// ----------------------------------------------------------------------------
module sfs_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [sfs_pkg::DIV_N_W-1:0] i_dividend,
    input  logic [sfs_pkg::DIV_D_W-1:0] i_divisor,
    output sfs_pkg::t_div_out          o_res
);

    logic [sfs_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                          r_done, n_done;
    logic [sfs_pkg::DIV_N_W-1:0]   r_quo, n_quo;
    logic [sfs_pkg::DIV_D_W-1:0]   r_rem, n_rem;
    logic [sfs_pkg::DIV_D_W-1:0]   r_dvs, n_dvs;
    logic [sfs_pkg::DIV_D_W:0]     trial;
    logic [sfs_pkg::DIV_D_W:0]     diff;
    logic                          fits;

    always_comb begin
        trial  = {r_rem, r_quo[sfs_pkg::DIV_N_W-1]};
        diff   = trial - {1'b0, r_dvs};
        fits   = (trial >= {1'b0, r_dvs});
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_cnt = sfs_pkg::DIV_CNT_W'(sfs_pkg::DIV_N_W);
            n_quo = i_dividend;
            n_rem = '0;
            n_dvs = i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == sfs_pkg::DIV_CNT_W'(1));
            // remainder stays below the divisor, so it fits DIV_D_W bits
            n_rem  = fits ? diff[sfs_pkg::DIV_D_W-1:0] : trial[sfs_pkg::DIV_D_W-1:0];
            n_quo  = {r_quo[sfs_pkg::DIV_N_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quo;
    assign o_res.rem  = r_rem;

endmodule

// ===== hw/rtl/sprite_frame_sequencer.sv =====
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// Sprite-sheet animation frame generator with a loadable draw-order table.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  command   in         start & !busy                i_req_type, i_entry_slot, i_entry_frame
//  result    out        o_result_valid (1 cycle)     o_frame_number, o_rect_x/y/w/h
//  config    in         i_cfg_valid & o_cfg_ready    i_cfg_index, i_cfg_data
//
//  A load word never raises busy.
//  A next-frame word passes through a table read, a wait on the bit-serial
//  dividers, a multiply stage and an output stage. Result strobes
//  the cycle busy drops. The table needs no clearing pass; reset is synchronous
//  and clears control state only. Config is always ready.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [7:0]  i_entry_slot,
    input  logic [11:0] i_entry_frame,
    output logic        o_result_valid,
    output logic [11:0] o_frame_number,
    output logic [17:0] o_rect_x,
    output logic [17:0] o_rect_y,
    output logic [12:0] o_rect_w,
    output logic [12:0] o_rect_h,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_MUL  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [6:0]  r_cols, r_rows;
    logic [15:0] r_period;
    logic [12:0] r_width, r_height;
    logic        r_custom;
    logic [8:0]  r_olen;

    // sequencing state
    logic [11:0] r_index, n_index;
    logic [15:0] r_tick, n_tick;
    logic [11:0] r_idx;
    logic [11:0] r_frame;

    // products and outputs
    logic [25:0] r_px, r_py;
    logic        r_valid;
    logic [11:0] r_out_frame;
    logic [17:0] r_out_x, r_out_y;
    logic [12:0] r_out_w, r_out_h;

    logic        accept, acc_frame, acc_load, slot_ok;
    logic [6:0]  cols, rows;
    logic [15:0] period;
    logic [8:0]  olen;
    logic [13:0] cell_count;
    logic [12:0] len;
    logic [11:0] idx;
    logic [12:0] idx_inc;
    logic [16:0] tick_inc;
    logic [11:0] frame;
    logic [11:0] rd_data;

    sfs_pkg::t_div_out w_res, h_res, f_res;

    assign accept    = start && !busy;
    assign acc_frame = accept && (i_req_type == sfs_pkg::REQ_FRAME);
    assign acc_load  = accept && (i_req_type == sfs_pkg::REQ_LOAD);
    assign slot_ok   = (32'(i_entry_slot) < 32'(sfs_pkg::ORDER_DEPTH));

    always_comb begin
        cols       = (r_cols == '0) ? 7'd1 : r_cols;
        rows       = (r_rows == '0) ? 7'd1 : r_rows;
        period     = (r_period == '0) ? 16'd1 : r_period;
        olen       = (r_olen == '0) ? 9'd1 : r_olen;
        cell_count = 14'(cols) * 14'(rows);
        if (r_custom) begin
            len = ({4'b0, olen} > 13'(sfs_pkg::ORDER_DEPTH)) ?
                  13'(sfs_pkg::ORDER_DEPTH) : {4'b0, olen};
        end else begin
            len = (cell_count > sfs_pkg::LEN_MAX) ? 13'(sfs_pkg::LEN_MAX)
                                                  : cell_count[12:0];
        end
        // index left past the length by a config change restarts at zero
        idx      = ({1'b0, r_index} < len) ? r_index : 12'd0;
        idx_inc  = {1'b0, idx} + 13'd1;
        tick_inc = {1'b0, r_tick} + 17'd1;
        n_tick   = r_tick;
        n_index  = r_index;
        if (acc_frame) begin
            if (tick_inc >= {1'b0, period}) begin
                n_tick  = '0;
                n_index = (idx_inc >= len) ? 12'd0 : idx_inc[11:0];
            end else begin
                n_tick  = tick_inc[15:0];
                n_index = idx;
            end
        end
        frame = r_custom ? rd_data : r_idx;
    end

    // load words and frame reads never share a cycle, so no forwarding
    sfs_order_ram u_order_ram (
        .i_clk   (i_clk),
        .i_we    (acc_load && slot_ok),
        .i_waddr (sfs_pkg::ADDR_W'(i_entry_slot)),
        .i_wdata (i_entry_frame),
        .i_raddr (idx[sfs_pkg::ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    sfs_div u_div_w (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (acc_frame),
        .i_dividend (r_width),
        .i_divisor  (cols),
        .o_res      (w_res)
    );

    sfs_div u_div_h (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (acc_frame),
        .i_dividend (r_height),
        .i_divisor  (rows),
        .o_res      (h_res)
    );

    // frame / cols starts in the cycle after the size dividers and finishes last
    sfs_div u_div_f (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_READ),
        .i_dividend ({1'b0, frame}),
        .i_divisor  (cols),
        .o_res      (f_res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc_frame) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_DIV;
            ST_DIV: begin
                if (f_res.done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= 1'b0;
            r_index  <= '0;
            r_tick   <= '0;
            r_cols   <= 7'd1;
            r_rows   <= 7'd1;
            r_period <= 16'd1;
            r_width  <= 13'd1;
            r_height <= 13'd1;
            r_custom <= 1'b0;
            r_olen   <= 9'd1;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_MUL);
            r_index <= n_index;
            r_tick  <= n_tick;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    sfs_pkg::CFG_SHEET_COLS:   r_cols   <= i_cfg_data[6:0];
                    sfs_pkg::CFG_SHEET_ROWS:   r_rows   <= i_cfg_data[6:0];
                    sfs_pkg::CFG_FRAME_PERIOD: r_period <= i_cfg_data;
                    sfs_pkg::CFG_SHEET_WIDTH:  r_width  <= i_cfg_data[12:0];
                    sfs_pkg::CFG_SHEET_HEIGHT: r_height <= i_cfg_data[12:0];
                    sfs_pkg::CFG_USE_CUSTOM:   r_custom <= i_cfg_data[0];
                    sfs_pkg::CFG_ORDER_LENGTH: r_olen   <= i_cfg_data[8:0];
                    default: ;
                endcase
            end
        end
    end

    // payload path
    always_ff @(posedge i_clk) begin
        if (acc_frame) begin
            r_idx <= idx;
        end
        if (r_state == ST_READ) begin
            r_frame <= frame;
        end
        if (r_state == ST_DIV && f_res.done) begin
            r_px <= 26'(f_res.rem) * 26'(w_res.quot);
            r_py <= 26'(f_res.quot) * 26'(h_res.quot);
        end
        if (r_state == ST_MUL) begin
            r_out_frame <= r_frame;
            r_out_x     <= (r_px > sfs_pkg::POS_MAX) ? 18'h3FFFF : r_px[17:0];
            r_out_y     <= (r_py > sfs_pkg::POS_MAX) ? 18'h3FFFF : r_py[17:0];
            r_out_w     <= w_res.quot;
            r_out_h     <= h_res.quot;
        end
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_valid;
    assign o_frame_number = r_out_frame;
    assign o_rect_x       = r_out_x;
    assign o_rect_y       = r_out_y;
    assign o_rect_w       = r_out_w;
    assign o_rect_h       = r_out_h;

`ifndef SYNTHESIS
    a_result_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state == ST_MUL))
        else $error("result strobe without multiply stage");

    a_size_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res.done || h_res.done) |-> (r_state == ST_DIV))
        else $error("size divider finished outside divide phase");

    a_frame_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type == sfs_pkg::REQ_FRAME) |=> (r_state == ST_READ))
        else $error("next-frame word did not start table read");

    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type == sfs_pkg::REQ_LOAD) |=> !busy)
        else $error("load word raised busy");
`endif

endmodule
